// File: rtl/dwm_pkg.sv
`timescale 1ns / 1ps
// Types, constants and the block-base table shared by the decimal word machine modules.
package dwm_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int BLOCK_WORDS = 10;

  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int SUM_W     = $clog2(MEM_WORDS + BLOCK_WORDS);
  localparam int OFF_W     = $clog2(BLOCK_WORDS + 1);
  localparam int CTR_W     = 7;
  localparam int WORD_W    = 32;
  localparam int OPER_SPAN = 1 << CTR_W;

  localparam logic [WORD_W-1:0] HASH_WORD = 32'h2323_2323;

  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_CARD = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_CARD = 2'd2;
  localparam logic [1:0] KIND_HALT = 2'd3;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVF   = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [CTR_W-1:0]  address;
    logic [WORD_W-1:0] data_word;
    logic [2:0]        char_count;
    logic              card_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] out_word;
    logic [3:0]        char_mask;
    logic              last;
    logic [CTR_W-1:0]  counter_value;
    logic [1:0]        fault;
  } out_item_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic [1:0]        command;
    logic              addr_ok;
    logic [MEM_AW-1:0] address;
    logic [WORD_W-1:0] data_word;
    logic [3:0]        lanes;
    logic              card_end;
  } job_t;

  typedef logic [OPER_SPAN-1:0][CTR_W-1:0] base_tbl_t;

  function automatic base_tbl_t make_base_tbl();
    base_tbl_t t;
    for (int i = 0; i < OPER_SPAN; i++) begin
      t[i] = CTR_W'(i - i % BLOCK_WORDS);
    end
    return t;
  endfunction

  // First word of the block that holds each operand.
  localparam base_tbl_t BASE_TBL = make_base_tbl();

endpackage

// File: rtl/dwm_front.sv
`timescale 1ns / 1ps
// Input side: accepts transactions, classifies them and queues them for the back.
module dwm_front import dwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     job_pop,
  output logic     job_empty,
  output job_t     job
);

  localparam int DEPTH = 2;

  job_t       slot_r [DEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       job_in;
  logic       wr, rd;

  always_comb begin
    job_in.command   = in_item.command;
    job_in.addr_ok   = in_item.address < CTR_W'(MEM_WORDS);
    job_in.address   = in_item.address[MEM_AW-1:0];
    job_in.data_word = in_item.data_word;
    job_in.card_end  = in_item.card_end;
    // Leading characters of a card word, top byte first; counts above four count as four.
    unique case (in_item.char_count)
      3'd0:    job_in.lanes = 4'b0000;
      3'd1:    job_in.lanes = 4'b1000;
      3'd2:    job_in.lanes = 4'b1100;
      3'd3:    job_in.lanes = 4'b1110;
      default: job_in.lanes = 4'b1111;
    endcase
  end

  assign full      = cnt_r == 2'(DEPTH);
  assign job_empty = cnt_r == 2'd0;
  assign job       = slot_r[rp_r];
  assign wr        = push && !full;
  assign rd        = job_pop && !job_empty;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= job_in;
    end
  end

endmodule

// File: rtl/dwm_back.sv
`timescale 1ns / 1ps
// Execution side: word memory, machine state and the instruction sequencer.
module dwm_back import dwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  output logic      job_pop,
  input  job_t      job,
  input  logic      rq_full,
  output logic      rq_push,
  output out_item_t rq_item
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECODE  = 3'd1;
  localparam logic [2:0] ST_OPER    = 3'd2;
  localparam logic [2:0] ST_PD_RD   = 3'd3;
  localparam logic [2:0] ST_PD_EMIT = 3'd4;
  localparam logic [2:0] ST_CARD_WR = 3'd5;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_GD   = 3'd1;
  localparam logic [2:0] OP_PD   = 3'd2;
  localparam logic [2:0] OP_LR   = 3'd3;
  localparam logic [2:0] OP_SR   = 3'd4;
  localparam logic [2:0] OP_CR   = 3'd5;
  localparam logic [2:0] OP_BT   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [WORD_W-1:0] gr_r, gr_nxt;
  logic              flag_r, flag_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic              await_r, await_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CTR_W-1:0]  cbase_r, cbase_nxt;
  logic [CTR_W-1:0]  pd_base_r, pd_base_nxt;
  logic [OFF_W-1:0]  pd_idx_r, pd_idx_nxt;
  logic [1:0]        pd_fault_r, pd_fault_nxt;
  logic              pd_oob_r, pd_oob_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [WORD_W-1:0] cw_data_r, cw_data_nxt;
  logic [3:0]        cw_lanes_r, cw_lanes_nxt;
  logic              cw_end_r, cw_end_nxt;
  logic [MEM_AW-1:0] cw_addr_r, cw_addr_nxt;

  logic [WORD_W-1:0]    word_mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [WORD_W-1:0]    rdata_r;
  logic                 rvld_r;

  logic              mem_we, mem_re, vld_clr;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [CTR_W:0]    ctr_inc;
  logic              adv_ok;
  logic [CTR_W-1:0]  adv_ctr;
  logic [1:0]        adv_fault;

  logic [WORD_W-1:0] rd_word;
  logic [7:0]        c0, c1, c2, c3;
  logic              digits_ok;
  logic [3:0]        d2, d3;
  logic [CTR_W-1:0]  operand;
  logic              oper_ok;
  logic [2:0]        dec_op;

  logic [SUM_W-1:0]  card_addr, pd_addr;
  logic              card_wr;
  logic              pd_last;
  logic [3:0]        pd_mask;

  // Counter advance: holds at the top word and reports overflow there.
  assign ctr_inc   = {1'b0, ctr_r} + 1'b1;
  assign adv_ok    = ctr_inc < (CTR_W+1)'(MEM_WORDS);
  assign adv_ctr   = adv_ok ? ctr_inc[CTR_W-1:0] : ctr_r;
  assign adv_fault = adv_ok ? FAULT_NONE : FAULT_OVF;

  // A word never written since reset or halt reads as zero.
  assign rd_word = rvld_r ? rdata_r : '0;

  assign c0 = rd_word[31:24];
  assign c1 = rd_word[23:16];
  assign c2 = rd_word[15:8];
  assign c3 = rd_word[7:0];
  assign digits_ok = c2 >= CH_ZERO && c2 <= CH_NINE && c3 >= CH_ZERO && c3 <= CH_NINE;
  assign d2 = 4'(c2 - CH_ZERO);
  assign d3 = 4'(c3 - CH_ZERO);
  assign operand = CTR_W'({d2, 3'b000}) + CTR_W'({d2, 1'b0}) + CTR_W'(d3);
  assign oper_ok = digits_ok && operand < CTR_W'(MEM_WORDS);

  always_comb begin
    if (c0 == CH_G && c1 == CH_D) begin
      dec_op = OP_GD;
    end else if (c0 == CH_P && c1 == CH_D) begin
      dec_op = OP_PD;
    end else if (c0 == CH_L && c1 == CH_R) begin
      dec_op = OP_LR;
    end else if (c0 == CH_S && c1 == CH_R) begin
      dec_op = OP_SR;
    end else if (c0 == CH_C && c1 == CH_R) begin
      dec_op = OP_CR;
    end else if (c0 == CH_B && c1 == CH_T) begin
      dec_op = OP_BT;
    end else begin
      dec_op = OP_NONE;
    end
  end

  assign card_addr = SUM_W'(cbase_r) + SUM_W'(off_r);
  assign pd_addr   = SUM_W'(pd_base_r) + SUM_W'(pd_idx_r);
  assign pd_last   = pd_idx_r == OFF_W'(BLOCK_WORDS - 1);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      pd_mask[b] = (!pd_oob_r) && (|rd_word[8*b +: 8]);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    gr_nxt       = gr_r;
    flag_nxt     = flag_r;
    ctr_nxt      = ctr_r;
    await_nxt    = await_r;
    off_nxt      = off_r;
    cbase_nxt    = cbase_r;
    pd_base_nxt  = pd_base_r;
    pd_idx_nxt   = pd_idx_r;
    pd_fault_nxt = pd_fault_r;
    pd_oob_nxt   = pd_oob_r;
    op_nxt       = op_r;
    cw_data_nxt  = cw_data_r;
    cw_lanes_nxt = cw_lanes_r;
    cw_end_nxt   = cw_end_r;
    cw_addr_nxt  = cw_addr_r;
    job_pop      = 1'b0;
    rq_push      = 1'b0;
    rq_item      = '0;
    rq_item.last = 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    vld_clr      = 1'b0;
    card_wr      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Every path out of here yields at most one result until a PD burst,
        // so a free result slot now is enough for the whole transaction.
        if (!job_empty && !rq_full) begin
          job_pop = 1'b1;
          case (job.command)
            CMD_LOAD: begin
              rq_push = 1'b1;
              rq_item.kind = KIND_DONE;
              if (job.addr_ok) begin
                mem_we    = 1'b1;
                mem_waddr = job.address;
                mem_wdata = job.data_word;
              end else begin
                rq_item.fault = FAULT_RANGE;
              end
            end
            CMD_STEP: begin
              if (await_r) begin
                rq_push = 1'b1;
                rq_item.kind = KIND_CARD;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ctr_r[MEM_AW-1:0];
                state_nxt = ST_DECODE;
              end
            end
            CMD_CARD: begin
              if (!await_r) begin
                rq_push = 1'b1;
                rq_item.kind = KIND_DONE;
              end else begin
                if (off_r < OFF_W'(BLOCK_WORDS)) begin
                  off_nxt = off_r + 1'b1;
                  if (card_addr < SUM_W'(MEM_WORDS) && job.lanes != 4'b0000) begin
                    card_wr      = 1'b1;
                    mem_re       = 1'b1;
                    mem_raddr    = card_addr[MEM_AW-1:0];
                    cw_addr_nxt  = card_addr[MEM_AW-1:0];
                    cw_data_nxt  = job.data_word;
                    cw_lanes_nxt = job.lanes;
                    cw_end_nxt   = job.card_end;
                    state_nxt    = ST_CARD_WR;
                  end
                end
                if (!card_wr && job.card_end) begin
                  await_nxt = 1'b0;
                  off_nxt   = '0;
                  ctr_nxt   = adv_ctr;
                  rq_push   = 1'b1;
                  rq_item.kind  = KIND_DONE;
                  rq_item.fault = adv_fault;
                end
              end
            end
            default: begin
              rq_push = 1'b1;
              rq_item.kind = KIND_DONE;
            end
          endcase
        end
      end

      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (dec_op == OP_NONE || !oper_ok) begin
          vld_clr   = 1'b1;
          gr_nxt    = HASH_WORD;
          flag_nxt  = 1'b0;
          ctr_nxt   = '0;
          await_nxt = 1'b0;
          off_nxt   = '0;
          cbase_nxt = '0;
          rq_push   = 1'b1;
          rq_item.kind  = KIND_HALT;
          rq_item.fault = (dec_op == OP_NONE) ? FAULT_NONE : FAULT_RANGE;
        end else begin
          case (dec_op)
            OP_GD: begin
              cbase_nxt = BASE_TBL[operand];
              off_nxt   = '0;
              await_nxt = 1'b1;
              rq_push   = 1'b1;
              rq_item.kind = KIND_CARD;
            end
            OP_PD: begin
              ctr_nxt      = adv_ctr;
              pd_fault_nxt = adv_fault;
              pd_base_nxt  = BASE_TBL[operand];
              pd_idx_nxt   = '0;
              state_nxt    = ST_PD_RD;
            end
            OP_SR: begin
              mem_we    = 1'b1;
              mem_waddr = operand[MEM_AW-1:0];
              mem_wdata = gr_r;
              ctr_nxt   = adv_ctr;
              rq_push   = 1'b1;
              rq_item.kind  = KIND_DONE;
              rq_item.fault = adv_fault;
            end
            OP_BT: begin
              rq_push = 1'b1;
              rq_item.kind = KIND_DONE;
              if (flag_r) begin
                ctr_nxt = operand;
              end else begin
                ctr_nxt = adv_ctr;
                rq_item.fault = adv_fault;
              end
            end
            default: begin
              // LR and CR need the operand word first.
              mem_re    = 1'b1;
              mem_raddr = operand[MEM_AW-1:0];
              op_nxt    = dec_op;
              state_nxt = ST_OPER;
            end
          endcase
        end
      end

      ST_OPER: begin
        if (op_r == OP_LR) begin
          gr_nxt = rd_word;
        end else begin
          flag_nxt = gr_r == rd_word;
        end
        ctr_nxt   = adv_ctr;
        rq_push   = 1'b1;
        rq_item.kind  = KIND_DONE;
        rq_item.fault = adv_fault;
        state_nxt = ST_IDLE;
      end

      ST_PD_RD: begin
        pd_oob_nxt = pd_addr >= SUM_W'(MEM_WORDS);
        if (pd_addr < SUM_W'(MEM_WORDS)) begin
          mem_re    = 1'b1;
          mem_raddr = pd_addr[MEM_AW-1:0];
        end
        state_nxt = ST_PD_EMIT;
      end

      ST_PD_EMIT: begin
        if (!rq_full) begin
          rq_push = 1'b1;
          rq_item.kind      = KIND_WORD;
          rq_item.out_word  = pd_oob_r ? '0 : rd_word;
          rq_item.char_mask = pd_mask;
          rq_item.last      = pd_last;
          rq_item.fault     = pd_fault_r;
          if (pd_last) begin
            state_nxt = ST_IDLE;
          end else begin
            pd_idx_nxt = pd_idx_r + 1'b1;
            state_nxt  = ST_PD_RD;
          end
        end
      end

      ST_CARD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cw_addr_r;
        for (int j = 0; j < 4; j++) begin
          mem_wdata[8*j +: 8] = cw_lanes_r[j] ? cw_data_r[8*j +: 8] : rd_word[8*j +: 8];
        end
        if (cw_end_r) begin
          await_nxt = 1'b0;
          off_nxt   = '0;
          ctr_nxt   = adv_ctr;
          rq_push   = 1'b1;
          rq_item.kind  = KIND_DONE;
          rq_item.fault = adv_fault;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rq_item.counter_value = ctr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gr_r    <= HASH_WORD;
      flag_r  <= 1'b0;
      ctr_r   <= '0;
      await_r <= 1'b0;
      off_r   <= '0;
      cbase_r <= '0;
    end else begin
      state_r <= state_nxt;
      gr_r    <= gr_nxt;
      flag_r  <= flag_nxt;
      ctr_r   <= ctr_nxt;
      await_r <= await_nxt;
      off_r   <= off_nxt;
      cbase_r <= cbase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pd_base_r  <= pd_base_nxt;
    pd_idx_r   <= pd_idx_nxt;
    pd_fault_r <= pd_fault_nxt;
    pd_oob_r   <= pd_oob_nxt;
    op_r       <= op_nxt;
    cw_data_r  <= cw_data_nxt;
    cw_lanes_r <= cw_lanes_nxt;
    cw_end_r   <= cw_end_nxt;
    cw_addr_r  <= cw_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= word_mem_r[mem_raddr];
    end
  end

  // One valid bit per word; halt drops them all at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (vld_clr) begin
        vld_r <= '0;
      end else if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rvld_r <= vld_r[mem_raddr];
      end
    end
  end

endmodule

// File: rtl/dwm_rq.sv
`timescale 1ns / 1ps
// Result queue that holds finished results until the receiver takes them.
module dwm_rq import dwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  out_item_t wr_item,
  output logic      full,
  input  logic      rd,
  output out_item_t rd_item,
  output logic      empty
);

  localparam int DEPTH = 4;

  out_item_t  slot_r [DEPTH];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full    = cnt_r == 3'(DEPTH);
  assign empty   = cnt_r == 3'd0;
  assign rd_item = slot_r[rp_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 2'd1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(do_wr) - 3'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_item;
    end
  end

endmodule

// File: rtl/decimal_word_machine_executor.sv
`timescale 1ns / 1ps
// Top level of the decimal word machine: front queue, executor and result queue.
//
// Input transactions are pushed with push while full is low; each carries a
// command (load a word, run one instruction, supply a card word or do nothing) and its data.
// Results come out as a queue: while empty is low the oldest result stands on
// out_item, and pop takes it. Every transaction gives one result, except a
// card word that is not the last of its line (none) and PD (ten words).
//
// The front takes one transaction per cycle, while full is low, into a two-entry
// queue. The executor runs one transaction at a time: a load, a card word
// without a write or a rejected step needs no read; a card write reads the old
// word, then writes it back with the new characters; a step does a fetch read of
// the word memory, then an operand read for LR and CR; PD reads and emits its
// block words one at a time through the single read port of the word memory.
//
// Synchronous reset (rst_n low) empties both queues, sets the register to four
// hash characters and clears the counter, toggle and card state. The word
// memory carries one valid bit per word, so reset and halt clear it at once.
// When the receiver stalls, the four-entry result queue fills, the executor
// waits, the front queue fills and full rises; nothing is lost.
module decimal_word_machine_executor import dwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      job_empty;
  logic      job_pop;
  job_t      job;
  logic      rq_full;
  logic      rq_push;
  out_item_t rq_item;

  // Front: classifies each transaction and queues it.
  dwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .job_pop   (job_pop),
    .job_empty (job_empty),
    .job       (job)
  );

  // Back: owns the word memory and machine state and runs the instructions.
  dwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job),
    .rq_full   (rq_full),
    .rq_push   (rq_push),
    .rq_item   (rq_item)
  );

  // Result queue: parts the executor from the receiver.
  dwm_rq u_rq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rq_push),
    .wr_item (rq_item),
    .full    (rq_full),
    .rd      (pop),
    .rd_item (out_item),
    .empty   (empty)
  );

endmodule

// File: rtl/dwm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the decimal word machine and the bind that attaches them.
module dwm_checker import dwm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  logic             take;
  logic             burst_r;
  logic [1:0]       bfault_r;
  logic [CTR_W-1:0] bctr_r;

  assign take = pop && !empty;

  // Set while a PD burst has words still to come.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= 1'b0;
    end else if (take) begin
      burst_r <= (out_item.kind == KIND_WORD) && !out_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bfault_r <= out_item.fault;
      bctr_r   <= out_item.counter_value;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed or vanished while stalled");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> empty && !full)
    else $error("queues not empty after reset");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    take && burst_r |-> out_item.kind == KIND_WORD && out_item.fault == bfault_r &&
                        out_item.counter_value == bctr_r)
    else $error("PD burst broken or inconsistent");

endmodule

bind decimal_word_machine_executor dwm_checker u_dwm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
